>>> rtl/imfrm_pkg.sv
package imfrm_pkg;

  localparam int unsigned PAYLOAD_BYTES = 31;
  localparam int unsigned PAY_IDX_W     = $clog2(PAYLOAD_BYTES);
  localparam logic [15:0] GOOD_LEN      = 16'(PAYLOAD_BYTES + 1);

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] IMU_COMMAND = 8'h81;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATE3 = 2'd3;

  localparam logic [CFG_W-1:0] SHORT_RST = 32'd5000;
  localparam logic [CFG_W-1:0] LATE1_RST = 32'd20000;
  localparam logic [CFG_W-1:0] LATE2_RST = 32'd40000;
  localparam logic [CFG_W-1:0] LATE3_RST = 32'd60000;

  typedef struct packed {
    logic [7:0]  seq_id;
    logic [15:0] heading;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic [15:0] right_range_mm;
    logic [15:0] left_range_mm;
    logic [7:0]  motion_dir;
    logic [31:0] interval_us;
    logic        gap_flag;
    logic [1:0]  late_class;
    logic        short_flag;
    logic [31:0] lost_total;
  } res_t;

endpackage

>>> rtl/imfrm_in_if.sv
interface imfrm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] stamp_us;

  modport source (output valid, output rx_byte, output stamp_us, input ready);
  modport sink (input valid, input rx_byte, input stamp_us, output ready);
endinterface

>>> rtl/imfrm_out_if.sv
interface imfrm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seq_id;
  logic [15:0] heading;
  logic [31:0] pos_x_bits;
  logic [31:0] pos_y_bits;
  logic [15:0] right_range_mm;
  logic [15:0] left_range_mm;
  logic [7:0]  motion_dir;
  logic [31:0] interval_us;
  logic        gap_flag;
  logic [1:0]  late_class;
  logic        short_flag;
  logic [31:0] lost_total;

  modport source (
    output valid, input ready,
    output seq_id, output heading, output pos_x_bits, output pos_y_bits,
    output right_range_mm, output left_range_mm, output motion_dir,
    output interval_us, output gap_flag, output late_class, output short_flag,
    output lost_total
  );
  modport sink (
    input valid, output ready,
    input seq_id, input heading, input pos_x_bits, input pos_y_bits,
    input right_range_mm, input left_range_mm, input motion_dir,
    input interval_us, input gap_flag, input late_class, input short_flag,
    input lost_total
  );
endinterface

>>> rtl/imu_frame_receiver_monitor_top.sv
// IMU frame receiver with link-quality monitor.
// in_if carries one received UART byte and its microsecond arrival stamp per
// transfer. The parser hunts for header 0xAA, reads a big-endian 16-bit length
// L and then L+1 body bytes (command, payload, unchecked check byte).
// A frame with command 0x81 and L == 32 yields one transfer on out_if: the
// decoded fields, sequence gap flag, saturating lost count, and the interval
// since the previous good frame classed against the cfg limits.
// Throughput: one byte per cycle while in_if.ready is high. The check byte's
// stamp goes into a one-entry frame stage; the monitor math (one 32-bit
// subtract, then compares) runs from that stage into the output register,
// which takes the result whenever it is empty or being read by out_if.
// Stalls: while out_if is stalled the output register holds; a further good
// frame waits in the frame stage and in_if.ready drops only while both are full.
// Reset (rst_n low, synchronous) returns the parser to header hunt, clears the
// monitor history and lost count, loads the default limits and empties both
// stages. cfg_we writes register cfg_idx: 0 short, 1 late1, 2 late2, 3 late3.
module imu_frame_receiver_monitor_top (
  input  logic                            clk,
  input  logic                            rst_n,
  imfrm_in_if.sink                        in_if,
  imfrm_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [imfrm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [imfrm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [31:0] short_lim_r, late1_lim_r, late2_lim_r, late3_lim_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  pay_r [imfrm_pkg::PAYLOAD_BYTES];
  logic        pay_we;
  logic [imfrm_pkg::PAY_IDX_W-1:0] pay_addr;
  logic        frame_good;

  logic        pend_r, pend_nxt;
  logic [31:0] pend_stamp_r;

  logic [7:0]  prev_seq_r;
  logic        prev_seen_r;
  logic [31:0] prev_stamp_r;
  logic [31:0] lost_r, lost_nxt;

  logic             out_valid_r, out_valid_nxt;
  imfrm_pkg::res_t  res_r, res_nxt;

  logic in_xfer, advance;
  logic [31:0] interval;
  logic [7:0]  id;
  logic        gap;
  logic [1:0]  late;
  logic        shrt;

  assign advance   = pend_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !pend_r || advance;
  assign in_xfer   = in_if.valid && in_if.ready;

  // Byte parser
  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    pay_we     = 1'b0;
    pay_addr   = imfrm_pkg::PAY_IDX_W'(idx_r - 16'd1);
    frame_good = 1'b0;
    if (in_xfer) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_if.rx_byte == imfrm_pkg::HEADER_BYTE) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {in_if.rx_byte, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {len_r[15:8], in_if.rx_byte};
          idx_nxt   = '0;
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          if (idx_r == '0) cmd_nxt = in_if.rx_byte;
          else if (idx_r <= 16'(imfrm_pkg::PAYLOAD_BYTES)) pay_we = 1'b1;
          if (idx_r >= len_r) begin
            frame_good = (cmd_r == imfrm_pkg::IMU_COMMAND) &&
                         (len_r == imfrm_pkg::GOOD_LEN);
            phase_nxt  = PH_HUNT;
            idx_nxt    = '0;
          end else begin
            idx_nxt = idx_r + 16'd1;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  assign pend_nxt = (pend_r && !advance) || frame_good;

  // Monitor math on the pending frame; payload is stable while it waits
  always_comb begin
    id       = pay_r[0];
    interval = 32'd0;
    gap      = 1'b0;
    late     = 2'd0;
    shrt     = 1'b0;
    lost_nxt = lost_r;
    if (prev_seen_r) begin
      interval = pend_stamp_r - prev_stamp_r;
      gap      = (prev_seq_r + 8'd1) != id;
      if (gap && (lost_r != '1)) lost_nxt = lost_r + 32'd1;
      priority if (interval > late3_lim_r) late = 2'd3;
      else if (interval > late2_lim_r) late = 2'd2;
      else if (interval > late1_lim_r) late = 2'd1;
      else late = 2'd0;
      shrt = interval < short_lim_r;
    end

    res_nxt.seq_id         = id;
    res_nxt.heading        = {pay_r[6], pay_r[7]};
    res_nxt.pos_x_bits     = {pay_r[18], pay_r[19], pay_r[20], pay_r[21]};
    res_nxt.pos_y_bits     = {pay_r[22], pay_r[23], pay_r[24], pay_r[25]};
    res_nxt.right_range_mm = {pay_r[26], pay_r[27]};
    res_nxt.left_range_mm  = {pay_r[28], pay_r[29]};
    res_nxt.motion_dir     = pay_r[30];
    res_nxt.interval_us    = interval;
    res_nxt.gap_flag       = gap;
    res_nxt.late_class     = late;
    res_nxt.short_flag     = shrt;
    res_nxt.lost_total     = lost_nxt;
  end

  assign out_valid_nxt = advance || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_lim_r  <= imfrm_pkg::SHORT_RST;
      late1_lim_r  <= imfrm_pkg::LATE1_RST;
      late2_lim_r  <= imfrm_pkg::LATE2_RST;
      late3_lim_r  <= imfrm_pkg::LATE3_RST;
      phase_r      <= PH_HUNT;
      len_r        <= '0;
      idx_r        <= '0;
      cmd_r        <= '0;
      pend_r       <= 1'b0;
      prev_seq_r   <= '0;
      prev_seen_r  <= 1'b0;
      prev_stamp_r <= '0;
      lost_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          imfrm_pkg::REG_SHORT: short_lim_r <= cfg_wdata;
          imfrm_pkg::REG_LATE1: late1_lim_r <= cfg_wdata;
          imfrm_pkg::REG_LATE2: late2_lim_r <= cfg_wdata;
          imfrm_pkg::REG_LATE3: late3_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      cmd_r       <= cmd_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        prev_seq_r   <= id;
        prev_seen_r  <= 1'b1;
        prev_stamp_r <= pend_stamp_r;
        lost_r       <= lost_nxt;
      end
    end
  end

  // Payload storage and datapath registers
  always_ff @(posedge clk) begin
    if (pay_we) pay_r[pay_addr] <= in_if.rx_byte;
    if (frame_good) pend_stamp_r <= in_if.stamp_us;
    if (advance) res_r <= res_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.seq_id         = res_r.seq_id;
  assign out_if.heading        = res_r.heading;
  assign out_if.pos_x_bits     = res_r.pos_x_bits;
  assign out_if.pos_y_bits     = res_r.pos_y_bits;
  assign out_if.right_range_mm = res_r.right_range_mm;
  assign out_if.left_range_mm  = res_r.left_range_mm;
  assign out_if.motion_dir     = res_r.motion_dir;
  assign out_if.interval_us    = res_r.interval_us;
  assign out_if.gap_flag       = res_r.gap_flag;
  assign out_if.late_class     = res_r.late_class;
  assign out_if.short_flag     = res_r.short_flag;
  assign out_if.lost_total     = res_r.lost_total;

endmodule

>>> rtl/imfrm_chk.sv
module imfrm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_seq_id,
  input logic [31:0] out_interval_us,
  input logic [31:0] out_lost_total
);

  // Empty output stage right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_seq_id) && $stable(out_interval_us)
      && $stable(out_lost_total))
    else $error("out payload changed under stall");

  // Input backpressure only comes from a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

endmodule

bind imu_frame_receiver_monitor_top imfrm_chk u_imfrm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_seq_id      (out_if.seq_id),
  .out_interval_us (out_if.interval_us),
  .out_lost_total  (out_if.lost_total)
);

>>> test/imu_frame_receiver_monitor_top_tb.sv
`timescale 1ns / 100ps

module imu_frame_receiver_monitor_top_tb;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    SEEK_HEADER,
    TAKE_LEN_HI,
    TAKE_LEN_LO,
    TAKE_BODY
  } parse_state_t;

  typedef enum logic {
    ROW_NOISE,
    ROW_FRAME
  } row_kind_t;

  // fill is the byte itself on a noise row
  typedef struct packed {
    row_kind_t       kind;
    logic [15:0]     len;
    logic [7:0]      cmd;
    logic [7:0]      seq;
    logic [7:0]      fill;
    logic [31:0]     stamp;
    bit              typed;
    imfrm_pkg::res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [imfrm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [imfrm_pkg::CFG_W-1:0] cfg_wdata;
  logic sink_ready = 1'b0;

  imfrm_in_if  byte_ch ();
  imfrm_out_if frame_ch ();

  assign frame_ch.ready = sink_ready;

  imu_frame_receiver_monitor_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (byte_ch),
    .out_if    (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  parse_state_t parse_st   = SEEK_HEADER;
  logic [15:0]  frame_len  = '0;
  logic [16:0]  body_idx   = '0;
  logic [7:0]   frame_cmd  = '0;
  logic [7:0]   payload_bytes [imfrm_pkg::PAYLOAD_BYTES];
  logic [7:0]   last_id    = '0;
  bit           have_prior = 1'b0;
  logic [31:0]  last_stamp = '0;
  logic [31:0]  gaps_seen  = '0;
  logic [31:0]  short_us   = imfrm_pkg::SHORT_RST;
  logic [31:0]  late1_us   = imfrm_pkg::LATE1_RST;
  logic [31:0]  late2_us   = imfrm_pkg::LATE2_RST;
  logic [31:0]  late3_us   = imfrm_pkg::LATE3_RST;

  imfrm_pkg::res_t expected_frames [$];
  imfrm_pkg::res_t head_frame;
  logic [7:0]  tx_payload [imfrm_pkg::PAYLOAD_BYTES];
  dir_row_t    plan [17];
  logic [31:0] now_us;
  int unsigned step_max;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned useful_bytes  = 0;
  int unsigned expected_total = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;

  function automatic bit decode_byte(input logic [7:0] b, input logic [31:0] st,
                                     output imfrm_pkg::res_t r);
    logic [31:0] gap_us;
    logic [7:0]  next_id;
    bit          hit;
    hit = 1'b0;
    r = '0;
    case (parse_st)
      SEEK_HEADER: if (b == imfrm_pkg::HEADER_BYTE) parse_st = TAKE_LEN_HI;
      TAKE_LEN_HI: begin
        frame_len = {b, 8'h00};
        parse_st = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        frame_len[7:0] = b;
        body_idx = '0;
        parse_st = TAKE_BODY;
      end
      default: begin
        if (body_idx == 17'd0) frame_cmd = b;
        else if (body_idx - 17'd1 < imfrm_pkg::PAYLOAD_BYTES)
          payload_bytes[body_idx - 17'd1] = b;
        if (body_idx >= 17'(frame_len)) begin
          if (frame_cmd == imfrm_pkg::IMU_COMMAND && frame_len == imfrm_pkg::GOOD_LEN) begin
            hit = 1'b1;
            gap_us = '0;
            if (have_prior) begin
              gap_us = st - last_stamp;
              next_id = last_id + 8'd1;
              if (next_id != payload_bytes[0]) begin
                r.gap_flag = 1'b1;
                if (gaps_seen != '1) gaps_seen = gaps_seen + 32'd1;
              end
              if (gap_us > late3_us) r.late_class = 2'd3;
              else if (gap_us > late2_us) r.late_class = 2'd2;
              else if (gap_us > late1_us) r.late_class = 2'd1;
              r.short_flag = (gap_us < short_us);
            end
            last_id = payload_bytes[0];
            last_stamp = st;
            have_prior = 1'b1;
            r.seq_id         = payload_bytes[0];
            r.heading        = {payload_bytes[6], payload_bytes[7]};
            r.pos_x_bits     = {payload_bytes[18], payload_bytes[19],
                                payload_bytes[20], payload_bytes[21]};
            r.pos_y_bits     = {payload_bytes[22], payload_bytes[23],
                                payload_bytes[24], payload_bytes[25]};
            r.right_range_mm = {payload_bytes[26], payload_bytes[27]};
            r.left_range_mm  = {payload_bytes[28], payload_bytes[29]};
            r.motion_dir     = payload_bytes[30];
            r.interval_us    = gap_us;
            r.lost_total     = gaps_seen;
          end
          parse_st = SEEK_HEADER;
          body_idx = '0;
        end else begin
          body_idx = body_idx + 17'd1;
        end
      end
    endcase
    return hit;
  endfunction

  function automatic logic [31:0] tick_us();
    now_us = now_us + 32'($urandom_range(step_max));
    return now_us;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [31:0] st, input bit typed,
                           input imfrm_pkg::res_t want);
    imfrm_pkg::res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid    <= 1'b1;
    byte_ch.rx_byte  <= b;
    byte_ch.stamp_us <= st;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (parse_st != SEEK_HEADER || b == imfrm_pkg::HEADER_BYTE) useful_bytes++;
    if (decode_byte(b, st, pred)) begin
      expected_frames.push_back(typed ? want : pred);
      expected_total++;
    end
  endtask

  // Payload comes from tx_payload; pin fixes the stamp of the check byte
  task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd, input bit pin,
                            input logic [31:0] pin_us, input bit typed,
                            input imfrm_pkg::res_t want);
    logic [7:0]  b;
    logic [31:0] st;
    send_byte(imfrm_pkg::HEADER_BYTE, tick_us(), 1'b0, '0);
    send_byte(len[15:8], tick_us(), 1'b0, '0);
    send_byte(len[7:0], tick_us(), 1'b0, '0);
    for (int unsigned i = 0; i <= len; i++) begin
      b = (i == 0) ? cmd : (i <= imfrm_pkg::PAYLOAD_BYTES) ? tx_payload[i-1] : 8'($urandom);
      st = tick_us();
      if (i == len && pin) begin
        st = pin_us;
        now_us = pin_us;
      end
      send_byte(b, st, typed && (i == len), want);
    end
  endtask

  task automatic finish_phase();
    byte_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [imfrm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [imfrm_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      imfrm_pkg::REG_SHORT: short_us = v;
      imfrm_pkg::REG_LATE1: late1_us = v;
      imfrm_pkg::REG_LATE2: late2_us = v;
      default:              late3_us = v;
    endcase
  endtask

  task automatic write_limits(input logic [31:0] s, input logic [31:0] l1,
                              input logic [31:0] l2, input logic [31:0] l3);
    write_reg(imfrm_pkg::REG_SHORT, s);
    write_reg(imfrm_pkg::REG_LATE1, l1);
    write_reg(imfrm_pkg::REG_LATE2, l2);
    write_reg(imfrm_pkg::REG_LATE3, l3);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles == RUN_LIMIT);
    $display("imu_frame_receiver_monitor_top_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && frame_ch.valid && frame_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $error("frame result with none expected, seq_id 0x%0h", frame_ch.seq_id);
        fails++;
      end else begin
        head_frame = expected_frames.pop_front();
        check_field("seq_id", head_frame.seq_id, frame_ch.seq_id);
        check_field("heading", head_frame.heading, frame_ch.heading);
        check_field("pos_x_bits", head_frame.pos_x_bits, frame_ch.pos_x_bits);
        check_field("pos_y_bits", head_frame.pos_y_bits, frame_ch.pos_y_bits);
        check_field("right_range_mm", head_frame.right_range_mm, frame_ch.right_range_mm);
        check_field("left_range_mm", head_frame.left_range_mm, frame_ch.left_range_mm);
        check_field("motion_dir", head_frame.motion_dir, frame_ch.motion_dir);
        check_field("interval_us", head_frame.interval_us, frame_ch.interval_us);
        check_field("gap_flag", head_frame.gap_flag, frame_ch.gap_flag);
        check_field("late_class", head_frame.late_class, frame_ch.late_class);
        check_field("short_flag", head_frame.short_flag, frame_ch.short_flag);
        check_field("lost_total", head_frame.lost_total, frame_ch.lost_total);
      end
    end
    sink_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    logic [31:0] pin_us, lim_a, lim_b;
    logic [15:0] len_tx;
    logic [7:0]  b;
    bit          pin;
    int unsigned pick, base_bytes, base_frames;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= imfrm_pkg::REG_SHORT;
    cfg_wdata        <= '0;
    byte_ch.valid    <= 1'b0;
    byte_ch.rx_byte  <= '0;
    byte_ch.stamp_us <= '0;
    now_us = $urandom;
    step_max = 100;

    plan[0]  = '{ROW_NOISE, 16'd0, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0, '0};
    plan[1]  = '{ROW_NOISE, 16'd0, 8'h00, 8'h00, 8'hFF, 32'd0, 1'b0, '0};
    plan[2]  = '{ROW_FRAME, 16'd0, imfrm_pkg::IMU_COMMAND, 8'h00, 8'h00, 32'd100, 1'b0, '0};
    plan[3]  = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, 8'h80, 8'h00, 8'h11, 32'd200, 1'b0, '0};
    plan[4]  = '{ROW_FRAME, 16'd31, imfrm_pkg::IMU_COMMAND, 8'h00, 8'h22, 32'd300, 1'b0, '0};
    plan[5]  = '{ROW_FRAME, 16'd33, imfrm_pkg::IMU_COMMAND, 8'h00, 8'h33, 32'd400, 1'b0, '0};
    plan[6]  = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h00, 8'h00,
                 32'h0000_0000, 1'b1,
                 {8'h00, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00,
                  32'h0, 1'b0, 2'd0, 1'b0, 32'd0}};
    plan[7]  = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h01, 8'hFF,
                 32'hFFFF_FFFF, 1'b1,
                 {8'h01, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                  32'hFFFF_FFFF, 1'b0, 2'd3, 1'b0, 32'd0}};
    plan[8]  = '{ROW_FRAME, 16'd31, imfrm_pkg::IMU_COMMAND, 8'h02, 8'h44, 32'd12345, 1'b0,
                 '0};
    plan[9]  = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h05, 8'h5A,
                 32'h0000_0010, 1'b1,
                 {8'h05, 16'h5A5A, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 16'h5A5A, 16'h5A5A, 8'h5A,
                  32'h0000_0011, 1'b1, 2'd0, 1'b1, 32'd1}};
    plan[10] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h06, 8'h3C,
                 32'd5016, 1'b0, '0};
    plan[11] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h07, 8'hC3,
                 32'd25016, 1'b0, '0};
    plan[12] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h08, 8'h96,
                 32'd45017, 1'b0, '0};
    plan[13] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h0A, 8'h69,
                 32'd85018, 1'b0, '0};
    plan[14] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'hFF, 8'h0F,
                 32'd145019, 1'b0, '0};
    plan[15] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h00, 8'hF0,
                 32'd150018, 1'b0, '0};
    plan[16] = '{ROW_FRAME, imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, 8'h01, 8'hAA,
                 32'd160000, 1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_NOISE) begin
        send_byte(plan[i].fill, tick_us(), 1'b0, '0);
      end else begin
        tx_payload[0] = plan[i].seq;
        for (int k = 1; k < imfrm_pkg::PAYLOAD_BYTES; k++) tx_payload[k] = plan[i].fill;
        send_frame(plan[i].len, plan[i].cmd, 1'b1, plan[i].stamp, plan[i].typed,
                   plan[i].want);
      end
    end
    finish_phase();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_limits('0, '0, '0, '0);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_limits('1, '1, '1, '1);
          send_idle_pct = 80;
          stall_pct = 0;
        end
        3: begin
          write_limits(imfrm_pkg::SHORT_RST, imfrm_pkg::LATE1_RST,
                       imfrm_pkg::LATE2_RST, imfrm_pkg::LATE3_RST);
          send_idle_pct = 36;
          stall_pct = 36;
        end
        4: begin
          write_limits($urandom_range(70000), $urandom_range(70000),
                       $urandom_range(70000), $urandom_range(70000));
          send_idle_pct = 0;
          stall_pct = 0;
        end
        default: begin
          lim_a = $urandom_range(30000);
          lim_b = lim_a + $urandom_range(30000);
          write_limits($urandom_range(8000), lim_a, lim_b, lim_b + $urandom_range(30000));
          send_idle_pct = (ph == 2) ? 0 : 36;
          stall_pct = (ph == 2) ? 80 : 36;
        end
      endcase

      base_bytes = useful_bytes;
      base_frames = expected_total;
      while (useful_bytes - base_bytes < 200 || expected_total - base_frames < 5) begin
        for (int k = 0; k < imfrm_pkg::PAYLOAD_BYTES; k++) tx_payload[k] = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 70) begin
          if ($urandom_range(9) != 0) tx_payload[0] = last_id + 8'd1;
          case ($urandom_range(5))
            0:       step_max = 20;
            1:       step_max = 600;
            2:       step_max = 1200;
            3:       step_max = 1800;
            4:       step_max = 3000;
            default: step_max = 4000;
          endcase
          pin = 1'b0;
          pin_us = '0;
          case ($urandom_range(19))
            0: begin
              // land on a limit, one below or one above
              case ($urandom_range(3))
                0:       lim_a = short_us;
                1:       lim_a = late1_us;
                2:       lim_a = late2_us;
                default: lim_a = late3_us;
              endcase
              pin = 1'b1;
              pin_us = last_stamp + lim_a + 32'($urandom_range(2)) - 32'd1;
            end
            1: begin
              pin = 1'b1;
              pin_us = $urandom;
            end
            default: ;
          endcase
          send_frame(imfrm_pkg::GOOD_LEN, imfrm_pkg::IMU_COMMAND, pin, pin_us, 1'b0, '0);
        end else if (pick < 80) begin
          send_frame(imfrm_pkg::GOOD_LEN, 8'($urandom), 1'b0, '0, 1'b0, '0);
        end else if (pick < 88) begin
          len_tx = ($urandom_range(9) == 0) ? 16'($urandom_range(300))
                                            : 16'($urandom_range(40));
          send_frame(len_tx,
                     ($urandom_range(1) == 0) ? imfrm_pkg::IMU_COMMAND : 8'($urandom),
                     1'b0, '0, 1'b0, '0);
        end else if (pick < 94) begin
          repeat ($urandom_range(4, 1)) begin
            b = 8'($urandom);
            if (b == imfrm_pkg::HEADER_BYTE) b = ~b;
            send_byte(b, tick_us(), 1'b0, '0);
          end
        end else begin
          // cut a frame short; the next frame's bytes complete it
          send_byte(imfrm_pkg::HEADER_BYTE, tick_us(), 1'b0, '0);
          send_byte(imfrm_pkg::GOOD_LEN[15:8], tick_us(), 1'b0, '0);
          send_byte(imfrm_pkg::GOOD_LEN[7:0], tick_us(), 1'b0, '0);
          send_byte(imfrm_pkg::IMU_COMMAND, tick_us(), 1'b0, '0);
          repeat ($urandom_range(30, 1)) send_byte(8'($urandom), tick_us(), 1'b0, '0);
        end
      end
      finish_phase();
    end

    if (fails == 0) $display("imu_frame_receiver_monitor_top_tb passed");
    else $display("imu_frame_receiver_monitor_top_tb failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/imfrm_pkg.sv
rtl/imfrm_in_if.sv
rtl/imfrm_out_if.sv
rtl/imu_frame_receiver_monitor_top.sv
rtl/imfrm_chk.sv
test/imu_frame_receiver_monitor_top_tb.sv
